// ===== src/dkf_pkg.sv =====
// Shared types and codes for the keyed FIFO with unique keys.
// Used by dkf_cell and dedup_keyed_fifo; depends on nothing.
package dkf_pkg;

    localparam int unsigned KEY_W = 32;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned OCC_W = 5;

    typedef enum logic [1:0] {
        REQ_ENQ  = 2'd0,
        REQ_DEQ  = 2'd1,
        REQ_PEEK = 2'd2,
        REQ_NONE = 2'd3
    } t_req_type;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    // Search item that walks the cell row, one cell per cycle.
    typedef struct packed {
        logic                     vld;
        logic signed [KEY_W-1:0]  key;
        logic                     hit;
        logic signed [DATA_W-1:0] data;
    } t_tok;

    // Broadcast control from the top level to every cell.
    typedef struct packed {
        logic                     shift;
        logic                     load;
        logic signed [KEY_W-1:0]  key;
        logic signed [DATA_W-1:0] data;
    } t_ctl;

endpackage

// ===== src/dedup_keyed_fifo.sv =====
// Top level of the keyed FIFO with unique keys: a row of dkf_cell storage
// cells, a small sequencer and a result register. Depends on dkf_pkg, dkf_cell.
//
//   channel   direction  handshake           payload
//   request   in         i_valid / o_stall   i_req_type, i_req_key, i_req_data
//   result    out        o_valid / i_stall   o_status, o_out_key, o_out_data, o_occupancy
//
// Dequeue and the unused request type load the result register in the cycle
// after they are accepted. Enqueue and peek send a search item along the row
// of DEPTH cells, one cell per cycle; one such request is in work at a time.
// Reset is synchronous and empties the queue; stored pairs are not cleared.
// A result waiting under i_stall raises o_stall, and a finished search waits
// until the result register is free.
module dedup_keyed_fifo
    import dkf_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [1:0]                i_req_type,
    input  logic signed [KEY_W-1:0]   i_req_key,
    input  logic signed [DATA_W-1:0]  i_req_data,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [2:0]                o_status,
    output logic signed [KEY_W-1:0]   o_out_key,
    output logic signed [DATA_W-1:0]  o_out_data,
    output logic [OCC_W-1:0]          o_occupancy
);

    localparam int CW = $clog2(DEPTH+1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_DONE   = 3'b100
    } t_state;

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    t_req_type                r_req_type;
    logic signed [KEY_W-1:0]  r_req_key;
    logic signed [DATA_W-1:0] r_req_data;
    logic                     r_hit;
    logic signed [DATA_W-1:0] r_hit_data;

    logic                     r_out_vld, n_out_vld;
    t_status                  r_status, n_status;
    logic signed [KEY_W-1:0]  r_out_key, n_out_key;
    logic signed [DATA_W-1:0] r_out_data, n_out_data;

    logic      out_free;
    logic      acc;
    logic      produce;
    t_req_type in_type;
    t_ctl      ctl;
    t_tok      tok_in;

    logic signed [KEY_W-1:0]  cell_key  [DEPTH];
    logic signed [DATA_W-1:0] cell_data [DEPTH];
    t_tok                     cell_tok  [DEPTH];

    assign in_type  = t_req_type'(i_req_type);
    assign out_free = !r_out_vld || !i_stall;
    assign o_stall  = !((r_state == S_IDLE) && out_free);
    assign acc      = i_valid && !o_stall;

    always_comb begin
        tok_in.vld  = acc && ((in_type == REQ_ENQ) || (in_type == REQ_PEEK));
        tok_in.key  = i_req_key;
        tok_in.hit  = 1'b0;
        tok_in.data = '0;
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [KEY_W-1:0]  nxt_key;
        logic signed [DATA_W-1:0] nxt_data;
        t_tok                     prv_tok;

        if (g == DEPTH - 1) begin : g_last
            assign nxt_key  = '0;
            assign nxt_data = '0;
        end else begin : g_mid
            assign nxt_key  = cell_key[g+1];
            assign nxt_data = cell_data[g+1];
        end

        if (g == 0) begin : g_first
            assign prv_tok = tok_in;
        end else begin : g_rest
            assign prv_tok = cell_tok[g-1];
        end

        dkf_cell #(
            .DEPTH (DEPTH),
            .IDX   (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_count    (r_count),
            .i_nxt_key  (nxt_key),
            .i_nxt_data (nxt_data),
            .i_tok      (prv_tok),
            .o_key      (cell_key[g]),
            .o_data     (cell_data[g]),
            .o_tok      (cell_tok[g])
        );
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_status   = r_status;
        n_out_key  = r_out_key;
        n_out_data = r_out_data;
        produce    = 1'b0;
        ctl.shift  = 1'b0;
        ctl.load   = 1'b0;
        ctl.key    = r_req_key;
        ctl.data   = r_req_data;

        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    unique case (in_type)
                        REQ_ENQ, REQ_PEEK: begin
                            n_state = S_SEARCH;
                        end
                        REQ_DEQ: begin
                            produce = 1'b1;
                            if (r_count == '0) begin
                                n_status   = ST_EMPTY;
                                n_out_key  = '0;
                                n_out_data = '0;
                            end else begin
                                n_status   = ST_OK;
                                n_out_key  = cell_key[0];
                                n_out_data = cell_data[0];
                                ctl.shift  = 1'b1;
                                n_count    = r_count - 1'b1;
                            end
                        end
                        REQ_NONE: begin
                            produce    = 1'b1;
                            n_status   = ST_OK;
                            n_out_key  = '0;
                            n_out_data = '0;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (cell_tok[DEPTH-1].vld) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    produce = 1'b1;
                    n_state = S_IDLE;
                    if (r_req_type == REQ_PEEK) begin
                        if (r_hit) begin
                            n_status   = ST_OK;
                            n_out_key  = r_req_key;
                            n_out_data = r_hit_data;
                        end else begin
                            n_status   = ST_NOTFOUND;
                            n_out_key  = '0;
                            n_out_data = '0;
                        end
                    end else begin
                        n_out_key  = '0;
                        n_out_data = '0;
                        if (r_hit) begin
                            n_status = ST_DUP;
                        end else if (r_count == CW'(DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            n_status = ST_OK;
                            ctl.load = 1'b1;
                            n_count  = r_count + 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_vld = produce || (r_out_vld && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_req_type <= in_type;
            r_req_key  <= i_req_key;
            r_req_data <= i_req_data;
        end
        if ((r_state == S_SEARCH) && cell_tok[DEPTH-1].vld) begin
            r_hit      <= cell_tok[DEPTH-1].hit;
            r_hit_data <= cell_tok[DEPTH-1].data;
        end
        if (produce) begin
            r_status   <= n_status;
            r_out_key  <= n_out_key;
            r_out_data <= n_out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (produce) begin
            o_occupancy <= OCC_W'(n_count);
        end
    end

    assign o_valid    = r_out_vld;
    assign o_status   = r_status;
    assign o_out_key  = r_out_key;
    assign o_out_data = r_out_data;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("Entry count exceeds the queue depth.");

    a_tok_only_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_tok[DEPTH-1].vld |-> (r_state == S_SEARCH))
        else $error("Search item left the cell row outside the search phase.");

    a_search_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && ((in_type == REQ_ENQ) || (in_type == REQ_PEEK))) |=> (r_state == S_SEARCH))
        else $error("Accepted enqueue or peek did not start a search.");

    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !produce |=> $stable(r_count))
        else $error("Entry count changed without a result.");

    a_deq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (in_type == REQ_DEQ) && (r_count != '0))
            |=> (r_count == CW'($past(r_count) - 1'b1)))
        else $error("Successful dequeue did not decrement the entry count.");

endmodule

// ===== src/dkf_cell.sv =====
// One storage cell of the keyed FIFO row: holds one key and data pair.
// It shifts toward the head on a dequeue and passes the search item on.
// Depends on dkf_pkg.
module dkf_cell
    import dkf_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int IDX = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_ctl                          i_ctl,
    input  logic [$clog2(DEPTH+1)-1:0]    i_count,
    input  logic signed [KEY_W-1:0]       i_nxt_key,
    input  logic signed [DATA_W-1:0]      i_nxt_data,
    input  t_tok                          i_tok,
    output logic signed [KEY_W-1:0]       o_key,
    output logic signed [DATA_W-1:0]      o_data,
    output t_tok                          o_tok
);

    localparam int CW = $clog2(DEPTH+1);

    logic signed [KEY_W-1:0]  r_key;
    logic signed [DATA_W-1:0] r_data;
    t_tok                     r_tok;
    t_tok                     n_tok;
    logic                     in_use;
    logic                     match;
    logic                     load_here;

    assign in_use    = CW'(IDX) < i_count;
    assign load_here = i_ctl.load && (CW'(IDX) == i_count);
    assign match     = in_use && (r_key == i_tok.key);

    always_comb begin
        n_tok      = i_tok;
        n_tok.hit  = i_tok.hit || match;
        n_tok.data = match ? r_data : i_tok.data;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_key  <= i_nxt_key;
            r_data <= i_nxt_data;
        end else if (load_here) begin
            r_key  <= i_ctl.key;
            r_data <= i_ctl.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_key  = r_key;
    assign o_data = r_data;
    assign o_tok  = r_tok;

endmodule
